// ===== sv/apss_pkg.sv =====
package apss_pkg;

	localparam int unsigned DefWordsPerSector = 256;
	localparam int unsigned DefDelayReads = 4;
	localparam logic [23:0] DefPollLimit = 24'd1000000;
	localparam logic [15:0] DefCommandBase = 16'd496;
	localparam logic [15:0] DefControlBase = 16'd1014;
	localparam logic [47:0] Lba28Max = 48'h000_0FFF_FFFF;

	localparam logic [2:0] CfgCapacity = 3'd0;
	localparam logic [2:0] CfgPresent = 3'd1;
	localparam logic [2:0] CfgSelect = 3'd2;
	localparam logic [2:0] CfgCmdBase = 3'd3;
	localparam logic [2:0] CfgCtlBase = 3'd4;
	localparam logic [2:0] CfgPollLimit = 3'd5;

	localparam logic [1:0] KindStart = 2'd0;
	localparam logic [1:0] KindReply = 2'd1;
	localparam logic [1:0] KindHostWord = 2'd2;

	localparam logic [2:0] ResBusRead = 3'd0;
	localparam logic [2:0] ResBusWrite = 3'd1;
	localparam logic [2:0] ResToHost = 3'd2;
	localparam logic [2:0] ResDone = 3'd3;
	localparam logic [2:0] ResNeedWord = 3'd4;

	localparam logic [1:0] FinOk = 2'd0;
	localparam logic [1:0] FinRejected = 2'd1;
	localparam logic [1:0] FinTimeout = 2'd2;
	localparam logic [1:0] FinDevError = 2'd3;

	localparam logic [7:0] StBsy = 8'h80;
	localparam logic [7:0] StDf = 8'h20;
	localparam logic [7:0] StDrq = 8'h08;
	localparam logic [7:0] StErr = 8'h01;

	localparam logic [7:0] DrvLba28 = 8'hE0;
	localparam logic [7:0] DrvLba48 = 8'h40;
	localparam logic [7:0] CmdRead = 8'h20;
	localparam logic [7:0] CmdReadExt = 8'h24;
	localparam logic [7:0] CmdWrite = 8'h30;
	localparam logic [7:0] CmdWriteExt = 8'h34;
	localparam logic [7:0] CmdFlush = 8'hE7;
	localparam logic [7:0] CmdFlushExt = 8'hEA;

	localparam logic [15:0] OffData = 16'd0;
	localparam logic [15:0] OffCount = 16'd2;
	localparam logic [15:0] OffLbaLo = 16'd3;
	localparam logic [15:0] OffLbaMid = 16'd4;
	localparam logic [15:0] OffLbaHi = 16'd5;
	localparam logic [15:0] OffDrive = 16'd6;
	localparam logic [15:0] OffCommand = 16'd7;

	typedef enum logic [5:0] {
		PH_IDLE       = 6'b000001,
		PH_WAIT_READY = 6'b000010,
		PH_WAIT_DRQ   = 6'b000100,
		PH_READ_DATA  = 6'b001000,
		PH_WRITE_DATA = 6'b010000,
		PH_FLUSH_WAIT = 6'b100000
	} phase_t;

	typedef struct packed {
		logic host;
		logic wword;
		logic prog;
		logic flush;
		logic wt;
		logic poll;
		logic dread;
		logic need;
		logic done;
	} seg_t;

	typedef struct packed {
		seg_t        seg;
		logic [1:0]  code;
		logic [15:0] value;
		logic [47:0] lba;
		logic        ext;
		logic        wmode;
	} job_t;

	typedef struct packed {
		logic [47:0] capacity;
		logic        present;
		logic        dsel;
		logic [15:0] cmd_base;
		logic [15:0] ctl_base;
		logic [23:0] poll_limit;
	} cfg_t;

endpackage

// ===== sv/apss_front.sv =====
module apss_front import apss_pkg::*; #(
	parameter int unsigned WORDS_PER_SECTOR = DefWordsPerSector
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        take,
	input  logic [1:0]  kind,
	input  logic [47:0] start_lba,
	input  logic [15:0] sector_total,
	input  logic        is_write,
	input  logic [15:0] reply_value,
	input  logic [15:0] host_word,
	output logic        push,
	output job_t        job
);

	localparam int unsigned WW = $clog2(WORDS_PER_SECTOR + 1);

	phase_t      phase_q, phase_d;
	logic [47:0] lba_q, lba_d;
	logic [15:0] left_q, left_d;
	logic [WW-1:0] word_q, word_d;
	logic [23:0] poll_q, poll_d;
	logic        wm_q, wm_d;

	logic [23:0] lim;
	logic [7:0]  st;
	logic [WW-1:0] wnext;
	logic [15:0] left_dec;
	logic        reject;

	assign lim = (cfg.poll_limit == 24'd0) ? 24'd1 : cfg.poll_limit;
	assign st = reply_value[7:0];
	assign wnext = word_q + WW'(1);
	assign left_dec = left_q - 16'd1;
	assign reject = !cfg.present || (sector_total == 16'd0) ||
		(({1'b0, start_lba} + {33'd0, sector_total}) > {1'b0, cfg.capacity});

	always_comb begin
		phase_d = phase_q;
		lba_d = lba_q;
		left_d = left_q;
		word_d = word_q;
		poll_d = poll_q;
		wm_d = wm_q;
		job = '0;
		job.lba = lba_q;
		job.ext = lba_q > Lba28Max;
		job.wmode = wm_q;
		case (kind)
			KindStart: begin
				if (phase_q != PH_IDLE) begin
					job.seg.done = 1'b1;
					job.code = FinRejected;
				end else if (reject) begin
					job.seg.done = 1'b1;
					job.code = FinRejected;
				end else begin
					lba_d = start_lba;
					left_d = sector_total;
					wm_d = is_write;
					word_d = '0;
					poll_d = 24'd1;
					phase_d = PH_WAIT_READY;
					job.seg.wt = 1'b1;
				end
			end
			KindReply: begin
				case (phase_q)
					PH_WAIT_READY: begin
						if ((st & StBsy) == 8'd0) begin
							job.seg.prog = 1'b1;
							job.seg.wt = 1'b1;
							poll_d = 24'd1;
							phase_d = PH_WAIT_DRQ;
						end else if (poll_q >= lim) begin
							job.seg.done = 1'b1;
							job.code = FinTimeout;
							phase_d = PH_IDLE;
						end else begin
							job.seg.poll = 1'b1;
							poll_d = poll_q + 24'd1;
						end
					end
					PH_WAIT_DRQ: begin
						if ((st & (StErr | StDf)) != 8'd0) begin
							job.seg.done = 1'b1;
							job.code = FinDevError;
							phase_d = PH_IDLE;
						end else if ((st & StBsy) == 8'd0 && (st & StDrq) != 8'd0) begin
							word_d = '0;
							if (wm_q) begin
								job.seg.need = 1'b1;
								phase_d = PH_WRITE_DATA;
							end else begin
								job.seg.dread = 1'b1;
								phase_d = PH_READ_DATA;
							end
						end else if (poll_q >= lim) begin
							job.seg.done = 1'b1;
							job.code = FinTimeout;
							phase_d = PH_IDLE;
						end else begin
							job.seg.poll = 1'b1;
							poll_d = poll_q + 24'd1;
						end
					end
					PH_READ_DATA: begin
						job.seg.host = 1'b1;
						job.value = reply_value;
						word_d = wnext;
						if (wnext < WW'(WORDS_PER_SECTOR)) begin
							job.seg.dread = 1'b1;
						end else begin
							lba_d = lba_q + 48'd1;
							left_d = left_dec;
							if (left_dec == 16'd0) begin
								job.seg.done = 1'b1;
								job.code = FinOk;
								phase_d = PH_IDLE;
							end else begin
								job.seg.wt = 1'b1;
								poll_d = 24'd1;
								phase_d = PH_WAIT_READY;
							end
						end
					end
					PH_FLUSH_WAIT: begin
						if ((st & StBsy) == 8'd0 || poll_q >= lim) begin
							lba_d = lba_q + 48'd1;
							left_d = left_dec;
							if (left_dec == 16'd0) begin
								job.seg.done = 1'b1;
								job.code = FinOk;
								phase_d = PH_IDLE;
							end else begin
								job.seg.wt = 1'b1;
								poll_d = 24'd1;
								phase_d = PH_WAIT_READY;
							end
						end else begin
							job.seg.poll = 1'b1;
							poll_d = poll_q + 24'd1;
						end
					end
					default: begin
					end
				endcase
			end
			KindHostWord: begin
				if (phase_q == PH_WRITE_DATA) begin
					job.seg.wword = 1'b1;
					job.value = host_word;
					word_d = wnext;
					if (wnext < WW'(WORDS_PER_SECTOR)) begin
						job.seg.need = 1'b1;
					end else begin
						job.seg.flush = 1'b1;
						job.seg.wt = 1'b1;
						poll_d = 24'd1;
						phase_d = PH_FLUSH_WAIT;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign push = take && (job.seg != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lba_q <= '0;
			left_q <= '0;
			word_q <= '0;
			poll_q <= '0;
			wm_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			lba_q <= lba_d;
			left_q <= left_d;
			word_q <= word_d;
			poll_q <= poll_d;
			wm_q <= wm_d;
		end
	end

endmodule

// ===== sv/apss_queue.sv =====
module apss_queue import apss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output job_t head
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ===== sv/apss_back.sv =====
module apss_back import apss_pkg::*; #(
	parameter int unsigned DELAY_READS = DefDelayReads
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_nonempty,
	input  job_t        q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [15:0] port_address,
	output logic [15:0] bus_value,
	output logic        word_wide,
	output logic        reply_expected,
	output logic [1:0]  finish_code,
	output logic        last
);

	localparam int unsigned CW = $clog2(DELAY_READS + 11);

	job_t        job_q;
	logic        jv_q;
	logic [CW-1:0] cnt_q;
	logic        ov_q;

	logic        adv, step;
	logic [2:0]  k;
	logic [15:0] pa, bv;
	logic        ww, re, seg_end, fin;
	seg_t        rest;
	logic [CW-1:0] r, idx;
	logic [7:0]  cmd, drv;
	logic [47:0] a;

	assign adv = !ov_q || !out_stall;
	assign step = jv_q && adv;
	assign a = job_q.lba;
	assign r = cnt_q - CW'(DELAY_READS + 1);
	assign idx = job_q.ext ? r : r + CW'(4);
	assign drv = job_q.ext ? (DrvLba48 | {3'd0, cfg.dsel, 4'd0}) :
		(DrvLba28 | {3'd0, cfg.dsel, a[27:24]});
	assign cmd = job_q.wmode ? (job_q.ext ? CmdWriteExt : CmdWrite) :
		(job_q.ext ? CmdReadExt : CmdRead);

	always_comb begin
		k = ResBusRead;
		pa = '0;
		bv = '0;
		ww = 1'b0;
		re = 1'b0;
		seg_end = 1'b1;
		rest = job_q.seg;
		if (job_q.seg.host) begin
			k = ResToHost;
			bv = job_q.value;
			rest.host = 1'b0;
		end else if (job_q.seg.wword) begin
			k = ResBusWrite;
			pa = cfg.cmd_base + OffData;
			bv = job_q.value;
			ww = 1'b1;
			rest.wword = 1'b0;
		end else if (job_q.seg.prog) begin
			seg_end = cnt_q == CW'(DELAY_READS + (job_q.ext ? 9 : 5));
			if (seg_end) begin
				rest.prog = 1'b0;
			end
			if (cnt_q == '0) begin
				k = ResBusWrite;
				pa = cfg.cmd_base + OffDrive;
				bv = {8'd0, drv};
			end else if (cnt_q <= CW'(DELAY_READS)) begin
				pa = cfg.ctl_base;
			end else begin
				k = ResBusWrite;
				case (idx)
					CW'(0): begin pa = cfg.cmd_base + OffCount; bv = '0; end
					CW'(1): begin pa = cfg.cmd_base + OffLbaLo; bv = {8'd0, a[31:24]}; end
					CW'(2): begin pa = cfg.cmd_base + OffLbaMid; bv = {8'd0, a[39:32]}; end
					CW'(3): begin pa = cfg.cmd_base + OffLbaHi; bv = {8'd0, a[47:40]}; end
					CW'(4): begin pa = cfg.cmd_base + OffCount; bv = 16'd1; end
					CW'(5): begin pa = cfg.cmd_base + OffLbaLo; bv = {8'd0, a[7:0]}; end
					CW'(6): begin pa = cfg.cmd_base + OffLbaMid; bv = {8'd0, a[15:8]}; end
					CW'(7): begin pa = cfg.cmd_base + OffLbaHi; bv = {8'd0, a[23:16]}; end
					default: begin pa = cfg.cmd_base + OffCommand; bv = {8'd0, cmd}; end
				endcase
			end
		end else if (job_q.seg.flush) begin
			k = ResBusWrite;
			pa = cfg.cmd_base + OffCommand;
			bv = {8'd0, job_q.ext ? CmdFlushExt : CmdFlush};
			rest.flush = 1'b0;
		end else if (job_q.seg.wt) begin
			seg_end = cnt_q == CW'(DELAY_READS);
			if (seg_end) begin
				pa = cfg.cmd_base + OffCommand;
				re = 1'b1;
				rest.wt = 1'b0;
			end else begin
				pa = cfg.ctl_base;
			end
		end else if (job_q.seg.poll) begin
			pa = cfg.cmd_base + OffCommand;
			re = 1'b1;
			rest.poll = 1'b0;
		end else if (job_q.seg.dread) begin
			pa = cfg.cmd_base + OffData;
			ww = 1'b1;
			re = 1'b1;
			rest.dread = 1'b0;
		end else if (job_q.seg.need) begin
			k = ResNeedWord;
			rest.need = 1'b0;
		end else begin
			k = ResDone;
			rest.done = 1'b0;
		end
	end

	assign fin = rest == '0;
	assign pop = q_nonempty && (!jv_q || (step && fin));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (pop) begin
				jv_q <= 1'b1;
				cnt_q <= '0;
			end else if (step) begin
				jv_q <= !fin;
				cnt_q <= seg_end ? '0 : cnt_q + CW'(1);
			end
			if (adv) begin
				ov_q <= jv_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end else if (step) begin
			job_q.seg <= rest;
		end
		if (step) begin
			result_kind <= k;
			port_address <= pa;
			bus_value <= bv;
			word_wide <= ww;
			reply_expected <= re;
			finish_code <= (k == ResDone) ? job_q.code : FinOk;
			last <= fin;
		end
	end

	assign out_valid = ov_q;

	a_job_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		jv_q |-> job_q.seg != '0)
		else $error("active job with no segments");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && result_kind == ResDone |-> last)
		else $error("done result not marked last");

endmodule

// ===== sv/ata_pio_sector_sequencer.sv =====
// ATA PIO sector sequencer, host side.
// Input channel (in_valid/in_stall): kind 0 starts a read or write request,
// kind 1 returns the reply to a bus read marked reply_expected, kind 2 hands
// over the next data word after a need-host-word result.
// Output channel (out_valid/out_stall): one result item per accepted handshake,
// in the order of the inputs that caused them; last marks the final result
// produced for one input item.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; write
// only while the block is idle.
// The front accepts an input item and puts its job into a queue of up to two
// entries; the back emits one result per cycle from its job while out_stall
// is low. An input's job passes through the queue, the back's job register and
// the output register before its first result; a single-result input can follow
// every cycle while out_stall is low. Program and wait sequences set the longest
// runs (up to 19 results with the default DELAY_READS). When the receiver stalls,
// the output register holds its item, the queue fills and then in_stall rises.
// Reset clears the request state to idle, empties the queue and the output,
// and loads the register defaults.
module ata_pio_sector_sequencer import apss_pkg::*; #(
	parameter int unsigned WORDS_PER_SECTOR = DefWordsPerSector,
	parameter int unsigned DELAY_READS = DefDelayReads
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [47:0] start_lba,
	input  logic [15:0] sector_total,
	input  logic        is_write,
	input  logic [15:0] reply_value,
	input  logic [15:0] host_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [15:0] port_address,
	output logic [15:0] bus_value,
	output logic        word_wide,
	output logic        reply_expected,
	output logic [1:0]  finish_code,
	output logic        last
);

	cfg_t cfg_q;
	logic full, nonempty, push, pop, take;
	job_t job, head;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign take = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity <= '0;
			cfg_q.present <= 1'b0;
			cfg_q.dsel <= 1'b0;
			cfg_q.cmd_base <= DefCommandBase;
			cfg_q.ctl_base <= DefControlBase;
			cfg_q.poll_limit <= DefPollLimit;
		end else if (cfg_valid) begin
			case (cfg_index)
				CfgCapacity: cfg_q.capacity <= cfg_data;
				CfgPresent: cfg_q.present <= cfg_data[0];
				CfgSelect: cfg_q.dsel <= cfg_data[0];
				CfgCmdBase: cfg_q.cmd_base <= cfg_data[15:0];
				CfgCtlBase: cfg_q.ctl_base <= cfg_data[15:0];
				CfgPollLimit: cfg_q.poll_limit <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	apss_front #(.WORDS_PER_SECTOR(WORDS_PER_SECTOR)) u_front (
		.clk, .arst_n, .cfg(cfg_q), .take, .kind, .start_lba, .sector_total,
		.is_write, .reply_value, .host_word, .push, .job
	);

	apss_queue u_queue (
		.clk, .arst_n, .push, .push_job(job), .pop, .full, .nonempty, .head
	);

	apss_back #(.DELAY_READS(DELAY_READS)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_nonempty(nonempty), .q_head(head), .pop,
		.out_valid, .out_stall, .result_kind, .port_address, .bus_value,
		.word_wide, .reply_expected, .finish_code, .last
	);

endmodule
